FILE: hw/rtl/rwl_pkg.sv
// rwl_pkg: command and status codes, controller states and the
// controller/datapath interface structs of the reader-writer lock manager
// no dependencies
`timescale 1ns / 1ps

package rwl_pkg;

   // request commands
   localparam logic [2:0] CMD_READ      = 3'd0;
   localparam logic [2:0] CMD_WRITE     = 3'd1;
   localparam logic [2:0] CMD_TRY_READ  = 3'd2;
   localparam logic [2:0] CMD_TRY_WRITE = 3'd3;
   localparam logic [2:0] CMD_UNLOCK    = 3'd4;

   // result status codes
   localparam logic [2:0] STS_GRANTED  = 3'd0;
   localparam logic [2:0] STS_BUSY     = 3'd1;
   localparam logic [2:0] STS_QUEUED   = 3'd2;
   localparam logic [2:0] STS_NOT_HELD = 3'd3;
   localparam logic [2:0] STS_WOKEN    = 3'd4;
   localparam logic [2:0] STS_RELEASED = 3'd5;
   localparam logic [2:0] STS_REFUSED  = 3'd6;

   // field widths of the stream words
   localparam int CMD_BITS     = 3;
   localparam int REQ_ID_BITS  = 8;
   localparam int STATUS_BITS  = 3;
   localparam int HOLDERS_BITS = 9;
   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 24;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_WAKE
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;     // request word taken this cycle
      logic emit_wake;  // load one wake result and pop its queue
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;    // result register empty or being drained
      logic wake_start;  // accepted request starts a wake sequence
      logic wake_final;  // one wake result left to send
   } dp_status_type;

endpackage

FILE: hw/rtl/rwl_ctrl.sv
// rwl_ctrl: controller state machine of the reader-writer lock manager
// depends on rwl_pkg
`timescale 1ns / 1ps

module rwl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  rwl_pkg::dp_status_type dp_status,
   output rwl_pkg::dp_cmd_type    dp_cmd
);

   rwl_pkg::ctrl_state_type state_ff, state_in;
   logic accept;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rwl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rwl_pkg::ST_IDLE: begin
            if (accept && dp_status.wake_start) begin
               state_in = rwl_pkg::ST_WAKE;
            end
         end
         rwl_pkg::ST_WAKE: begin
            if (dp_status.out_free && dp_status.wake_final) begin
               state_in = rwl_pkg::ST_IDLE;
            end
         end
         default: state_in = rwl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready       = 1'b0;
      dp_cmd.accept    = 1'b0;
      dp_cmd.emit_wake = 1'b0;
      case (state_ff)
         rwl_pkg::ST_IDLE: begin
            req_tready    = dp_status.out_free;
            dp_cmd.accept = req_tvalid && dp_status.out_free;
         end
         rwl_pkg::ST_WAKE: begin
            dp_cmd.emit_wake = dp_status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/rwl_datapath.sv
// rwl_datapath: holder count, reader and writer wait queues, request
// decision logic and the result register
// depends on rwl_pkg
`timescale 1ns / 1ps

module rwl_datapath #(
   parameter int READER_QUEUE_DEPTH = 16,
   parameter int WRITER_QUEUE_DEPTH = 16,
   parameter int ID_BITS            = 8,
   parameter int MAX_READERS        = 255
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [rwl_pkg::CMD_BITS-1:0]            req_command,
   input  logic [rwl_pkg::REQ_ID_BITS-1:0]         req_requester_id,
   input  rwl_pkg::dp_cmd_type                     dp_cmd,
   output rwl_pkg::dp_status_type                  dp_status,
   input  logic                                    rsp_tready,
   output logic                                    rsp_tvalid,
   output logic [rwl_pkg::STATUS_BITS-1:0]         rsp_status,
   output logic [rwl_pkg::REQ_ID_BITS-1:0]         rsp_agent_id,
   output logic signed [rwl_pkg::HOLDERS_BITS-1:0] rsp_holders,
   output logic                                    rsp_last
);

   localparam int HC_BITS  = $clog2(MAX_READERS + 1) + 1;
   localparam int RQ_PTR   = (READER_QUEUE_DEPTH > 1) ? $clog2(READER_QUEUE_DEPTH) : 1;
   localparam int WQ_PTR   = (WRITER_QUEUE_DEPTH > 1) ? $clog2(WRITER_QUEUE_DEPTH) : 1;
   localparam int RQ_FILL  = $clog2(READER_QUEUE_DEPTH + 1);
   localparam int WQ_FILL  = $clog2(WRITER_QUEUE_DEPTH + 1);
   localparam int HB       = rwl_pkg::HOLDERS_BITS;

   localparam logic signed [HC_BITS-1:0] HC_ZERO   = '0;
   localparam logic signed [HC_BITS-1:0] HC_ONE    = HC_BITS'(1);
   localparam logic signed [HC_BITS-1:0] HC_WRITER = '1;
   localparam logic signed [HC_BITS-1:0] HC_MAX    = HC_BITS'(MAX_READERS);
   localparam logic [RQ_FILL-1:0] RQ_FULL = RQ_FILL'(READER_QUEUE_DEPTH);
   localparam logic [WQ_FILL-1:0] WQ_FULL = WQ_FILL'(WRITER_QUEUE_DEPTH);
   localparam logic [RQ_PTR-1:0]  RQ_LAST = RQ_PTR'(READER_QUEUE_DEPTH - 1);
   localparam logic [WQ_PTR-1:0]  WQ_LAST = WQ_PTR'(WRITER_QUEUE_DEPTH - 1);

   // lock state
   logic signed [HC_BITS-1:0] hc_ff, hc_in;
   logic [RQ_PTR-1:0]  rq_head_ff, rq_head_in;
   logic [RQ_FILL-1:0] rq_fill_ff, rq_fill_in;
   logic [WQ_PTR-1:0]  wq_head_ff, wq_head_in;
   logic [WQ_FILL-1:0] wq_fill_ff, wq_fill_in;

   // wake sequence
   logic [RQ_FILL-1:0] wake_cnt_ff, wake_cnt_in;
   logic               wake_wr_ff, wake_wr_in;
   logic [HB-1:0]      hold_ff, hold_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic [2:0]           out_status_ff, out_status_in;
   logic [7:0]           out_agent_ff, out_agent_in;
   logic signed [HB-1:0] out_holders_ff, out_holders_in;
   logic                 out_last_ff, out_last_in;

   // queue memories
   logic [ID_BITS-1:0] rq_mem [READER_QUEUE_DEPTH];
   logic [ID_BITS-1:0] wq_mem [WRITER_QUEUE_DEPTH];
   logic [ID_BITS-1:0] rq_rdata_ff, wq_rdata_ff;
   logic [RQ_PTR-1:0]  rq_rd_addr, rq_head_inc, rq_tail;
   logic [WQ_PTR-1:0]  wq_rd_addr, wq_head_inc, wq_tail;
   logic [RQ_PTR:0]    rq_tail_sum;
   logic [WQ_PTR:0]    wq_tail_sum;

   logic               out_free, push_r, push_w, pop_r, pop_w;
   logic               has_result, wake_start;
   logic [2:0]         sts;
   logic [ID_BITS-1:0] id;
   logic [RQ_FILL-1:0] wake_n;
   logic               read_ok;

   assign out_free = !out_valid_ff || rsp_tready;
   assign id       = ID_BITS'(req_requester_id);
   assign read_ok  = (hc_ff >= HC_ZERO) && (wq_fill_ff == '0);

   assign rq_head_inc = (rq_head_ff == RQ_LAST) ? '0 : rq_head_ff + RQ_PTR'(1);
   assign wq_head_inc = (wq_head_ff == WQ_LAST) ? '0 : wq_head_ff + WQ_PTR'(1);
   assign rq_tail_sum = (RQ_PTR + 1)'(rq_head_ff) + (RQ_PTR + 1)'(rq_fill_ff);
   assign wq_tail_sum = (WQ_PTR + 1)'(wq_head_ff) + (WQ_PTR + 1)'(wq_fill_ff);
   assign rq_tail = (rq_tail_sum >= (RQ_PTR + 1)'(READER_QUEUE_DEPTH)) ?
                    RQ_PTR'(rq_tail_sum - (RQ_PTR + 1)'(READER_QUEUE_DEPTH)) :
                    RQ_PTR'(rq_tail_sum);
   assign wq_tail = (wq_tail_sum >= (WQ_PTR + 1)'(WRITER_QUEUE_DEPTH)) ?
                    WQ_PTR'(wq_tail_sum - (WQ_PTR + 1)'(WRITER_QUEUE_DEPTH)) :
                    WQ_PTR'(wq_tail_sum);

   // readers woken on a final release: all queued, capped at the reader limit
   assign wake_n = (int'(rq_fill_ff) > MAX_READERS) ? RQ_FILL'(MAX_READERS) : rq_fill_ff;

   // request decision
   always_comb begin
      hc_in      = hc_ff;
      sts        = rwl_pkg::STS_GRANTED;
      has_result = 1'b1;
      push_r     = 1'b0;
      push_w     = 1'b0;
      wake_start = 1'b0;
      wake_cnt_in = wake_cnt_ff;
      wake_wr_in  = wake_wr_ff;
      case (req_command)
         rwl_pkg::CMD_READ, rwl_pkg::CMD_TRY_READ: begin
            if (read_ok) begin
               if (hc_ff >= HC_MAX) begin
                  sts = rwl_pkg::STS_REFUSED;
               end else begin
                  hc_in = hc_ff + HC_ONE;
               end
            end else if (req_command == rwl_pkg::CMD_TRY_READ) begin
               sts = rwl_pkg::STS_BUSY;
            end else if (rq_fill_ff >= RQ_FULL) begin
               sts = rwl_pkg::STS_REFUSED;
            end else begin
               sts    = rwl_pkg::STS_QUEUED;
               push_r = 1'b1;
            end
         end
         rwl_pkg::CMD_WRITE, rwl_pkg::CMD_TRY_WRITE: begin
            if (hc_ff == HC_ZERO) begin
               hc_in = HC_WRITER;
            end else if (req_command == rwl_pkg::CMD_TRY_WRITE) begin
               sts = rwl_pkg::STS_BUSY;
            end else if (wq_fill_ff >= WQ_FULL) begin
               sts = rwl_pkg::STS_REFUSED;
            end else begin
               sts    = rwl_pkg::STS_QUEUED;
               push_w = 1'b1;
            end
         end
         rwl_pkg::CMD_UNLOCK: begin
            if (hc_ff == HC_ZERO) begin
               sts = rwl_pkg::STS_NOT_HELD;
            end else if (hc_ff > HC_ONE) begin
               sts   = rwl_pkg::STS_RELEASED;
               hc_in = hc_ff - HC_ONE;
            end else begin
               // final release: hand over to a writer first, else to readers
               sts = rwl_pkg::STS_RELEASED;
               if (wq_fill_ff != '0) begin
                  hc_in       = HC_WRITER;
                  wake_start  = 1'b1;
                  wake_wr_in  = 1'b1;
                  wake_cnt_in = RQ_FILL'(1);
               end else begin
                  hc_in       = HC_BITS'(wake_n);
                  wake_start  = (wake_n != '0);
                  wake_wr_in  = 1'b0;
                  wake_cnt_in = wake_n;
               end
            end
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   assign pop_r = dp_cmd.emit_wake && !wake_wr_ff;
   assign pop_w = dp_cmd.emit_wake && wake_wr_ff;
   assign rq_rd_addr = pop_r ? rq_head_inc : rq_head_ff;
   assign wq_rd_addr = pop_w ? wq_head_inc : wq_head_ff;

   // next values of state, queue pointers and result register
   always_comb begin
      rq_head_in     = rq_head_ff;
      rq_fill_in     = rq_fill_ff;
      wq_head_in     = wq_head_ff;
      wq_fill_in     = wq_fill_ff;
      hold_in        = hold_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_status_in  = out_status_ff;
      out_agent_in   = out_agent_ff;
      out_holders_in = out_holders_ff;
      out_last_in    = out_last_ff;
      if (dp_cmd.accept) begin
         if (push_r) begin
            rq_fill_in = rq_fill_ff + RQ_FILL'(1);
         end
         if (push_w) begin
            wq_fill_in = wq_fill_ff + WQ_FILL'(1);
         end
         hold_in = HB'(hc_in);
         if (has_result) begin
            out_valid_in   = 1'b1;
            out_status_in  = sts;
            out_agent_in   = 8'(id);
            out_holders_in = HB'(hc_in);
            out_last_in    = !wake_start;
         end
      end
      if (dp_cmd.emit_wake) begin
         out_valid_in   = 1'b1;
         out_status_in  = rwl_pkg::STS_WOKEN;
         out_agent_in   = wake_wr_ff ? 8'(wq_rdata_ff) : 8'(rq_rdata_ff);
         out_holders_in = hold_ff;
         out_last_in    = (wake_cnt_ff == RQ_FILL'(1));
         if (pop_r) begin
            rq_head_in = rq_head_inc;
            rq_fill_in = rq_fill_ff - RQ_FILL'(1);
         end
         if (pop_w) begin
            wq_head_in = wq_head_inc;
            wq_fill_in = wq_fill_ff - WQ_FILL'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff        <= HC_ZERO;
         rq_head_ff   <= '0;
         rq_fill_ff   <= '0;
         wq_head_ff   <= '0;
         wq_fill_ff   <= '0;
         wake_cnt_ff  <= '0;
         wake_wr_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (dp_cmd.accept) begin
            hc_ff <= hc_in;
         end
         rq_head_ff   <= rq_head_in;
         rq_fill_ff   <= rq_fill_in;
         wq_head_ff   <= wq_head_in;
         wq_fill_ff   <= wq_fill_in;
         out_valid_ff <= out_valid_in;
         if (dp_cmd.accept && wake_start) begin
            wake_cnt_ff <= wake_cnt_in;
            wake_wr_ff  <= wake_wr_in;
         end else if (dp_cmd.emit_wake) begin
            wake_cnt_ff <= wake_cnt_ff - RQ_FILL'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_ff        <= hold_in;
      out_status_ff  <= out_status_in;
      out_agent_ff   <= out_agent_in;
      out_holders_ff <= out_holders_in;
      out_last_ff    <= out_last_in;
   end

   // wait queues: push at the tail, head entry read ahead into a register
   always_ff @(posedge clock) begin
      if (dp_cmd.accept && push_r) begin
         rq_mem[rq_tail] <= id;
      end
      rq_rdata_ff <= rq_mem[rq_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.accept && push_w) begin
         wq_mem[wq_tail] <= id;
      end
      wq_rdata_ff <= wq_mem[wq_rd_addr];
   end

   assign dp_status.out_free   = out_free;
   assign dp_status.wake_start = wake_start;
   assign dp_status.wake_final = (wake_cnt_ff == RQ_FILL'(1));

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_agent_id = out_agent_ff;
   assign rsp_holders  = out_holders_ff;
   assign rsp_last     = out_last_ff;

endmodule

FILE: hw/rtl/reader_writer_lock_manager.sv
// reader_writer_lock_manager: top level of the writer-priority
// reader-writer lock; joins rwl_ctrl and rwl_datapath
// depends on rwl_pkg, rwl_ctrl, rwl_datapath
`timescale 1ns / 1ps

// usage
// - req channel: one word per lock request (command, requester id)
// - rsp channel: one or more result words per request, tlast on the final
//   one; unknown commands give no result
// - a request that causes a single result is taken and its result
//   appears on rsp the cycle after; such requests go back to back
//   while the receiver keeps up
// - the final release of a lock is followed by one wake word per woken
//   waiter: one for a writer, or one per reader up to the reader limit;
//   these leave the reader or writer queue one per cycle while the receiver
//   keeps up, and req_tready stays low until the last of them is loaded
// - every result of a request carries the holder count after the request
// - the single result register holds its word while rsp_tready is low;
//   req_tready then drops and no request is taken until it drains
// - synchronous reset frees the lock and empties both queues at once;
//   queue entries themselves are not cleared

module reader_writer_lock_manager #(
   parameter int READER_QUEUE_DEPTH = 16,
   parameter int WRITER_QUEUE_DEPTH = 16,
   parameter int ID_BITS            = 8,
   parameter int MAX_READERS        = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [2:0] command, [10:3] requester_id
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] status, [10:3] agent_id, [19:11] holders
   output logic        rsp_tlast
);

   rwl_pkg::dp_cmd_type    dp_cmd;
   rwl_pkg::dp_status_type dp_status;

   logic [2:0]        rsp_status;
   logic [7:0]        rsp_agent_id;
   logic signed [8:0] rsp_holders;

   rwl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd)
   );

   rwl_datapath #(
      .READER_QUEUE_DEPTH (READER_QUEUE_DEPTH),
      .WRITER_QUEUE_DEPTH (WRITER_QUEUE_DEPTH),
      .ID_BITS            (ID_BITS),
      .MAX_READERS        (MAX_READERS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_tdata[2:0]),
      .req_requester_id (req_tdata[10:3]),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_status       (rsp_status),
      .rsp_agent_id     (rsp_agent_id),
      .rsp_holders      (rsp_holders),
      .rsp_last         (rsp_tlast)
   );

   // result word, zero padded to whole bytes
   assign rsp_tdata = {4'b0000, rsp_holders, rsp_agent_id, rsp_status};

endmodule

FILE: hw/rtl/rwl_chk.sv
// rwl_chk: port-level checks of the reader-writer lock manager, bound
// to the top level
// depends on rwl_pkg, reader_writer_lock_manager
`timescale 1ns / 1ps

module rwl_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   else $error("rsp word changed while stalled");

   // reset leaves the result channel empty
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
   else $error("rsp valid after reset");

   // no request is taken while a result sequence is still unfinished
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
   else $error("request accepted during wake sequence");

   // woken waiters always leave the lock held
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == rwl_pkg::STS_WOKEN |-> rsp_tdata[19:11] != 9'd0)
   else $error("wake result with free lock");

   // every taken non-final result word is followed by a wake word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && rsp_tdata[2:0] == rwl_pkg::STS_WOKEN)
   else $error("wake word missing after non-final result");

endmodule

bind reader_writer_lock_manager rwl_chk u_rwl_chk (.*);
